### sv/trapezoid_velocity_profile_top_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the trapezoid velocity profile block
// Shared property forms, clocked on clock and disabled while reset is high.
// -----------------------------------------------------------------------------
`ifndef TRAPEZOID_VELOCITY_PROFILE_TOP_ASSERT_SVH
`define TRAPEZOID_VELOCITY_PROFILE_TOP_ASSERT_SVH

// same-cycle implication
`define TVP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TVP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/tvp_pkg.sv
// -----------------------------------------------------------------------------
// tvp_pkg
// Widths, codes and controller/datapath interface types of the profile block.
// -----------------------------------------------------------------------------
package tvp_pkg;

   localparam int DIST_WIDTH     = 32;
   localparam int RATE_WIDTH     = 16;
   localparam int ACCEL_WIDTH    = 12;
   localparam int MAX_WIDTH      = 15;
   localparam int CSR_WIDTH      = 15;
   localparam int RAMP_WIDTH     = 16;
   localparam int CRUISE_WIDTH   = 32;
   localparam int DP_WIDTH       = DIST_WIDTH + ACCEL_WIDTH;   // d*a
   localparam int DVS_WIDTH      = ACCEL_WIDTH + MAX_WIDTH;    // a*m
   localparam int MM_WIDTH       = 2 * MAX_WIDTH;
   localparam int MUL_A_WIDTH    = 32;
   localparam int MUL_B_WIDTH    = 16;
   localparam int MUL_P_WIDTH    = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int DIV_CNT_WIDTH  = 6;
   localparam int RSP_DATA_WIDTH = 24;
   localparam int RSP_PAD_WIDTH  = RSP_DATA_WIDTH - RATE_WIDTH - 3;

   localparam logic [ACCEL_WIDTH-1:0] ACCEL_RESET = 12'd41;
   localparam logic [MAX_WIDTH-1:0]   MAX_RESET   = 15'd4096;

   // register indexes
   localparam logic CSR_ACCEL = 1'b0;
   localparam logic CSR_MAX   = 1'b1;

   // item kinds
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // profile phases
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_UP     = 2'd1;
   localparam logic [1:0] PH_CRUISE = 2'd2;
   localparam logic [1:0] PH_DOWN   = 2'd3;

   // shared multiplier operand selects
   localparam logic [1:0] MUL_DA = 2'd0;
   localparam logic [1:0] MUL_MM = 2'd1;
   localparam logic [1:0] MUL_AM = 2'd2;
   localparam logic [1:0] MUL_RR = 2'd3;

   // divider jobs
   localparam logic [1:0] DIV_TRI    = 2'd0;
   localparam logic [1:0] DIV_CRUISE = 2'd1;
   localparam logic [1:0] DIV_RAMP   = 2'd2;

   localparam logic [DIV_CNT_WIDTH-1:0] DIV_TRI_BITS    = 6'd32;
   localparam logic [DIV_CNT_WIDTH-1:0] DIV_CRUISE_BITS = 6'd44;
   localparam logic [DIV_CNT_WIDTH-1:0] DIV_RAMP_BITS   = 6'd16;

   typedef struct packed {
      logic       capture;
      logic       tick;
      logic       hold;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       div_start;
      logic [1:0] div_sel;
      logic       sqrt_start;
      logic       save_cruise;
      logic       fin_tri;
      logic       fin_trap;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic tri_move;
      logic div_busy;
      logic sqrt_busy;
   } status_type;

endpackage

### sv/trapezoid_velocity_profile_top.sv
// -----------------------------------------------------------------------------
// trapezoid_velocity_profile_top
// Trapezoidal / triangular rate profile generator with stream ports.
// -----------------------------------------------------------------------------
// A start word (tuser 0) plans a move from a signed distance; each tick word
// (tuser 1) steps the profile one command period and returns the signed rate.
// Every word gives exactly one response word. A tick's response is valid in
// the cycle after acceptance. A start while idle runs the planner: three
// products on the shared multiplier and a compare step, then the
// one-bit-per-cycle divider (32 steps for a triangular move, 44 plus 16 for a
// trapezoid) and, for a triangular move, a 16-step square root and one more
// product. No new word is taken while planning. A start while a move is
// running is answered at once with the current state. Registers are written
// through the csr port; the user must write them only while idle, the block
// itself does not enforce this.
// -----------------------------------------------------------------------------
module trapezoid_velocity_profile_top import tvp_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic signed [DIST_WIDTH-1:0] req_tdata,   // [31:0] distance
   input  logic                         req_tuser,   // [0] func
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [15:0] rate_command, [16] active, [18:17] phase_out, [23:19] zero
   output logic [RSP_DATA_WIDTH-1:0]    rsp_tdata,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [CSR_WIDTH-1:0]         csr_wdata
);

   cmd_type    cmd;
   status_type status;

   tvp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tvp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .distance  (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_tdata)
   );

endmodule

### sv/tvp_datapath.sv
// -----------------------------------------------------------------------------
// tvp_datapath
// Config registers, planning units (shared multiplier, restoring divider,
// square root) and the per-tick profile state with the response register.
// -----------------------------------------------------------------------------
module tvp_datapath import tvp_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [CSR_WIDTH-1:0]         csr_wdata,
   input  logic signed [DIST_WIDTH-1:0] distance,
   input  cmd_type                      cmd,
   output status_type                   status,
   output logic [RSP_DATA_WIDTH-1:0]    rsp_data
);

   typedef struct packed {
      logic [1:0]              phase;
      logic [MAX_WIDTH-1:0]    rate;
      logic                    dir;
      logic [RAMP_WIDTH-1:0]   ramp;
      logic [CRUISE_WIDTH-1:0] cruise;
      logic [CRUISE_WIDTH-1:0] tcnt;
   } prof_type;

   localparam logic [31:0] SQ_TOP = 32'h4000_0000;

   // ---------------- configuration
   logic [ACCEL_WIDTH-1:0] accel_ff, accel_in, a_eff;
   logic [MAX_WIDTH-1:0]   max_ff, max_in, m_eff;

   always_comb begin
      accel_in = accel_ff;
      max_in   = max_ff;
      if (csr_we) begin
         if (csr_index == CSR_ACCEL) begin
            accel_in = csr_wdata[ACCEL_WIDTH-1:0];
         end else begin
            max_in = csr_wdata[MAX_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= ACCEL_RESET;
         max_ff   <= MAX_RESET;
      end else begin
         accel_ff <= accel_in;
         max_ff   <= max_in;
      end
   end

   // zero register values act as one
   assign a_eff = (accel_ff == '0) ? ACCEL_WIDTH'(1) : accel_ff;
   assign m_eff = (max_ff == '0) ? MAX_WIDTH'(1) : max_ff;

   // ---------------- start capture
   logic [DIST_WIDTH-1:0]  dist_raw, dist_abs;
   logic [DIST_WIDTH-1:0]  dist_ff, dist_in;
   logic                   neg_ff, neg_in;
   logic [ACCEL_WIDTH-1:0] pa_ff, pa_in;
   logic [MAX_WIDTH-1:0]   pm_ff, pm_in;

   assign dist_raw = distance;
   assign dist_abs = dist_raw[DIST_WIDTH-1] ? (~dist_raw + DIST_WIDTH'(1)) : dist_raw;

   always_comb begin
      dist_in = cmd.capture ? dist_abs : dist_ff;
      neg_in  = cmd.capture ? dist_raw[DIST_WIDTH-1] : neg_ff;
      pa_in   = cmd.capture ? a_eff : pa_ff;
      pm_in   = cmd.capture ? m_eff : pm_ff;
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      neg_ff  <= neg_in;
      pa_ff   <= pa_in;
      pm_ff   <= pm_in;
   end

   // ---------------- shared multiplier, one product per cycle
   logic [MUL_A_WIDTH-1:0] mul_a;
   logic [MUL_B_WIDTH-1:0] mul_b;
   logic [MUL_P_WIDTH-1:0] mul_p;
   logic [DP_WIDTH-1:0]    p_da_ff, p_da_in;
   logic [MM_WIDTH-1:0]    p_mm_ff, p_mm_in;
   logic [DVS_WIDTH-1:0]   p_am_ff, p_am_in;
   logic [31:0]            p_rr_ff, p_rr_in;
   logic [31:0]            sq_r_ff, sq_r_in;

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_DA: begin
            mul_a = dist_ff;
            mul_b = MUL_B_WIDTH'(pa_ff);
         end
         MUL_MM: begin
            mul_a = MUL_A_WIDTH'(pm_ff);
            mul_b = MUL_B_WIDTH'(pm_ff);
         end
         MUL_AM: begin
            mul_a = MUL_A_WIDTH'(pa_ff);
            mul_b = MUL_B_WIDTH'(pm_ff);
         end
         MUL_RR: begin
            mul_a = MUL_A_WIDTH'(sq_r_ff[15:0]);
            mul_b = sq_r_ff[15:0];
         end
      endcase
      mul_p = MUL_P_WIDTH'(mul_a) * MUL_P_WIDTH'(mul_b);
   end

   always_comb begin
      p_da_in = (cmd.mul_en && cmd.mul_sel == MUL_DA) ? mul_p[DP_WIDTH-1:0] : p_da_ff;
      p_mm_in = (cmd.mul_en && cmd.mul_sel == MUL_MM) ? mul_p[MM_WIDTH-1:0] : p_mm_ff;
      p_am_in = (cmd.mul_en && cmd.mul_sel == MUL_AM) ? mul_p[DVS_WIDTH-1:0] : p_am_ff;
      p_rr_in = (cmd.mul_en && cmd.mul_sel == MUL_RR) ? mul_p[31:0] : p_rr_ff;
   end

   always_ff @(posedge clock) begin
      p_da_ff <= p_da_in;
      p_mm_ff <= p_mm_in;
      p_am_ff <= p_am_in;
      p_rr_ff <= p_rr_in;
   end

   // ---------------- restoring divider, one quotient bit per cycle
   // The dividend is loaded left-justified so short jobs run fewer steps;
   // the quotient ends up right-justified in quo_ff.
   logic [DP_WIDTH-1:0]      quo_ff, quo_in, numer;
   logic [DVS_WIDTH-1:0]     rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DIV_CNT_WIDTH-1:0] dcnt_ff, dcnt_in;
   logic [DVS_WIDTH:0]       shifted;
   logic [DVS_WIDTH+1:0]     diff;
   logic [RAMP_WIDTH-1:0]    ramp_num;

   assign numer    = p_da_ff - DP_WIDTH'(p_mm_ff);
   assign ramp_num = RAMP_WIDTH'(pm_ff) + RAMP_WIDTH'(pa_ff) - RAMP_WIDTH'(1);

   always_comb begin
      shifted = {rem_ff, quo_ff[DP_WIDTH-1]};
      diff    = {1'b0, shifted} - (DVS_WIDTH+2)'(dvs_ff);
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_start) begin
         rem_in = '0;
         unique case (cmd.div_sel)
            DIV_TRI: begin
               quo_in  = {dist_ff, {(DP_WIDTH-DIST_WIDTH){1'b0}}};
               dvs_in  = DVS_WIDTH'(pa_ff);
               dcnt_in = DIV_TRI_BITS;
            end
            DIV_CRUISE: begin
               quo_in  = numer;
               dvs_in  = p_am_ff;
               dcnt_in = DIV_CRUISE_BITS;
            end
            DIV_RAMP: begin
               quo_in  = {ramp_num, {(DP_WIDTH-RAMP_WIDTH){1'b0}}};
               dvs_in  = DVS_WIDTH'(pa_ff);
               dcnt_in = DIV_RAMP_BITS;
            end
            default: begin
               dcnt_in = '0;
            end
         endcase
      end else if (dcnt_ff != '0) begin
         rem_in  = diff[DVS_WIDTH+1] ? shifted[DVS_WIDTH-1:0] : diff[DVS_WIDTH-1:0];
         quo_in  = {quo_ff[DP_WIDTH-2:0], ~diff[DVS_WIDTH+1]};
         dcnt_in = dcnt_ff - DIV_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else begin
         dcnt_ff <= dcnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   // ---------------- integer square root, two radicand bits per cycle
   logic [31:0] sq_x_ff, sq_x_in, sq_b_ff, sq_b_in, q_ff, q_in;
   logic [32:0] sq_t;

   always_comb begin
      sq_t    = {1'b0, sq_r_ff} + {1'b0, sq_b_ff};
      sq_x_in = sq_x_ff;
      sq_r_in = sq_r_ff;
      sq_b_in = sq_b_ff;
      q_in    = q_ff;
      if (cmd.sqrt_start) begin
         sq_x_in = quo_ff[31:0];
         q_in    = quo_ff[31:0];
         sq_r_in = '0;
         sq_b_in = SQ_TOP;
      end else if (sq_b_ff != '0) begin
         if ({1'b0, sq_x_ff} >= sq_t) begin
            sq_x_in = sq_x_ff - sq_t[31:0];
            sq_r_in = (sq_r_ff >> 1) + sq_b_ff;
         end else begin
            sq_r_in = sq_r_ff >> 1;
         end
         sq_b_in = sq_b_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_b_ff <= '0;
      end else begin
         sq_b_ff <= sq_b_in;
      end
      sq_x_ff <= sq_x_in;
      sq_r_ff <= sq_r_in;
      q_ff    <= q_in;
   end

   // ---------------- plan results
   logic [RAMP_WIDTH:0]     n_wide;
   logic [RAMP_WIDTH-1:0]   n_tri;
   logic [CRUISE_WIDTH-1:0] cruise_sat, pc_ff, pc_in;

   always_comb begin
      n_wide = (p_rr_ff < q_ff) ? ((RAMP_WIDTH+1)'(sq_r_ff[15:0]) + (RAMP_WIDTH+1)'(1))
                                : (RAMP_WIDTH+1)'(sq_r_ff[15:0]);
      n_tri  = n_wide[RAMP_WIDTH] ? '1 : n_wide[RAMP_WIDTH-1:0];
      cruise_sat = (quo_ff[DP_WIDTH-1:CRUISE_WIDTH] != '0) ? '1 : quo_ff[CRUISE_WIDTH-1:0];
      pc_in  = cmd.save_cruise ? cruise_sat : pc_ff;
   end

   always_ff @(posedge clock) begin
      pc_ff <= pc_in;
   end

   // ---------------- profile state
   prof_type                prof_ff, prof_in;
   logic [RATE_WIDTH-1:0]   rate_sum, rate_mag, rate_out;
   logic [CRUISE_WIDTH-1:0] tcnt_inc;

   always_comb begin
      prof_in  = prof_ff;
      rate_sum = RATE_WIDTH'(prof_ff.rate) + RATE_WIDTH'(a_eff);
      tcnt_inc = prof_ff.tcnt + CRUISE_WIDTH'(1);
      if (cmd.tick) begin
         unique case (prof_ff.phase)
            PH_UP: begin
               prof_in.rate = (rate_sum >= RATE_WIDTH'(m_eff)) ? m_eff
                                                               : rate_sum[MAX_WIDTH-1:0];
               prof_in.tcnt = tcnt_inc;
               if (tcnt_inc >= CRUISE_WIDTH'(prof_ff.ramp)) begin
                  prof_in.tcnt  = '0;
                  prof_in.phase = (prof_ff.cruise != '0) ? PH_CRUISE : PH_DOWN;
               end
            end
            PH_CRUISE: begin
               prof_in.tcnt = tcnt_inc;
               if (tcnt_inc >= prof_ff.cruise) begin
                  prof_in.tcnt  = '0;
                  prof_in.phase = PH_DOWN;
               end
            end
            PH_DOWN: begin
               prof_in.rate = (prof_ff.rate > MAX_WIDTH'(a_eff))
                              ? prof_ff.rate - MAX_WIDTH'(a_eff) : '0;
               prof_in.tcnt = tcnt_inc;
               if (tcnt_inc >= CRUISE_WIDTH'(prof_ff.ramp)) begin
                  prof_in.tcnt  = '0;
                  prof_in.rate  = '0;
                  prof_in.phase = PH_IDLE;
               end
            end
            PH_IDLE: begin
               prof_in.rate = '0;
            end
         endcase
      end else if (cmd.fin_tri) begin
         prof_in.dir    = neg_ff;
         prof_in.tcnt   = '0;
         prof_in.rate   = '0;
         prof_in.ramp   = n_tri;
         prof_in.cruise = '0;
         prof_in.phase  = (n_tri == '0) ? PH_IDLE : PH_UP;
      end else if (cmd.fin_trap) begin
         prof_in.dir    = neg_ff;
         prof_in.tcnt   = '0;
         prof_in.rate   = '0;
         prof_in.ramp   = quo_ff[RAMP_WIDTH-1:0];
         prof_in.cruise = pc_ff;
         prof_in.phase  = PH_UP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prof_ff <= '{phase: PH_IDLE, rate: '0, dir: 1'b0, ramp: '0, cruise: '0, tcnt: '0};
      end else begin
         prof_ff <= prof_in;
      end
   end

   // ---------------- response word
   logic [RSP_DATA_WIDTH-1:0] rsp_ff, rsp_in;
   logic                      out_load;

   assign out_load = cmd.tick | cmd.hold | cmd.fin_tri | cmd.fin_trap;
   assign rate_mag = RATE_WIDTH'(prof_in.rate);
   assign rate_out = prof_in.dir ? (~rate_mag + RATE_WIDTH'(1)) : rate_mag;

   always_comb begin
      rsp_in = rsp_ff;
      if (out_load) begin
         rsp_in = {{RSP_PAD_WIDTH{1'b0}}, prof_in.phase, (prof_in.phase != PH_IDLE), rate_out};
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data         = rsp_ff;
   assign status.active    = (prof_ff.phase != PH_IDLE);
   assign status.tri_move  = (p_da_ff <= DP_WIDTH'(p_mm_ff));
   assign status.div_busy  = (dcnt_ff != '0);
   assign status.sqrt_busy = (sq_b_ff != '0);

endmodule

### sv/tvp_ctrl.sv
// -----------------------------------------------------------------------------
// tvp_ctrl
// Handshake and planning sequencer: drives the datapath one step at a time.
// -----------------------------------------------------------------------------
module tvp_ctrl import tvp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_func,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_MUL_DA   = 4'd1;
   localparam logic [3:0] S_MUL_MM   = 4'd2;
   localparam logic [3:0] S_MUL_AM   = 4'd3;
   localparam logic [3:0] S_CMP      = 4'd4;
   localparam logic [3:0] S_DIV_Q    = 4'd5;
   localparam logic [3:0] S_SQRT     = 4'd6;
   localparam logic [3:0] S_MUL_RR   = 4'd7;
   localparam logic [3:0] S_FIN_TRI  = 4'd8;
   localparam logic [3:0] S_DIV_C    = 4'd9;
   localparam logic [3:0] S_DIV_R    = 4'd10;
   localparam logic [3:0] S_FIN_TRAP = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free, accept, out_load;

   // response register may be reloaded in the cycle it drains
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == S_IDLE) & out_free;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_TICK) begin
                  cmd.tick = 1'b1;
               end else if (status.active) begin
                  cmd.hold = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = S_MUL_DA;
               end
            end
         end
         S_MUL_DA: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DA;
            state_in    = S_MUL_MM;
         end
         S_MUL_MM: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_MM;
            state_in    = S_MUL_AM;
         end
         S_MUL_AM: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_AM;
            state_in    = S_CMP;
         end
         S_CMP: begin
            cmd.div_start = 1'b1;
            if (status.tri_move) begin
               cmd.div_sel = DIV_TRI;
               state_in    = S_DIV_Q;
            end else begin
               cmd.div_sel = DIV_CRUISE;
               state_in    = S_DIV_C;
            end
         end
         S_DIV_Q: begin
            if (!status.div_busy) begin
               cmd.sqrt_start = 1'b1;
               state_in       = S_SQRT;
            end
         end
         S_SQRT: begin
            if (!status.sqrt_busy) begin
               state_in = S_MUL_RR;
            end
         end
         S_MUL_RR: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RR;
            state_in    = S_FIN_TRI;
         end
         S_FIN_TRI: begin
            if (out_free) begin
               cmd.fin_tri = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_DIV_C: begin
            if (!status.div_busy) begin
               cmd.save_cruise = 1'b1;
               cmd.div_start   = 1'b1;
               cmd.div_sel     = DIV_RAMP;
               state_in        = S_DIV_R;
            end
         end
         S_DIV_R: begin
            if (!status.div_busy) begin
               state_in = S_FIN_TRAP;
            end
         end
         S_FIN_TRAP: begin
            if (out_free) begin
               cmd.fin_trap = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_load = cmd.tick | cmd.hold | cmd.fin_tri | cmd.fin_trap;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### sv/tvp_checker.sv
// -----------------------------------------------------------------------------
// tvp_checker
// Port-level checks of the profile block, bound to the top level.
// -----------------------------------------------------------------------------
`include "trapezoid_velocity_profile_top_assert.svh"

module tvp_checker import tvp_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // stalled response word holds
   `TVP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response word changed while stalled")

   // idle words carry no rate and no active flag
   `TVP_ASSERT_IMPLIES(a_idle_zero, rsp_tvalid && (rsp_tdata[18:17] == PH_IDLE), (rsp_tdata[16] == 1'b0) && (rsp_tdata[15:0] == '0), "idle response with nonzero rate")

   `TVP_ASSERT_IMPLIES(a_active_phase, rsp_tvalid, rsp_tdata[16] == (rsp_tdata[18:17] != PH_IDLE), "active flag disagrees with phase")

   // a tick is answered in the next cycle
   `TVP_ASSERT_NEXT(a_tick_reply, req_tvalid && req_tready && (req_tuser == FUNC_TICK), rsp_tvalid, "tick word got no response")

endmodule

bind trapezoid_velocity_profile_top tvp_checker u_tvp_checker (.*);
